// ===== rtl/metp_pkg.sv =====
// Shared constants, types and controller/datapath interface for the escape-time pixel unit.
package metp_pkg;

    localparam int FRAC_BITS   = 28;
    localparam int COLOR_COUNT = 90;

    localparam int WORD_W      = 32;
    localparam int PROD_W      = 2 * WORD_W;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_IDX_W   = 3;
    localparam int MAX_ITER_W  = 16;
    localparam int PALETTE_W   = 7;
    localparam int QUOT_W      = $clog2(COLOR_COUNT);
    localparam int COLOR_W     = $clog2(COLOR_COUNT + 1);
    localparam int STEP_W      = $clog2(QUOT_W + 1);

    localparam logic [MAX_ITER_W-1:0] MAX_ITER_RESET = MAX_ITER_W'(60);

    localparam logic [CFG_IDX_W-1:0] CFG_X_ORIGIN = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_X_STEP   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_Y_ORIGIN = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_Y_STEP   = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER = CFG_IDX_W'(4);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MAP,
        S_IT_MUL,
        S_IT_UPD,
        S_DIV_INIT,
        S_DIV_STEP,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic map_add;
        logic it_mul;
        logic it_upd;
        logic div_init;
        logic div_step;
    } t_dp_cmd;

    typedef struct packed {
        logic it_finish;
    } t_dp_status;

endpackage

// ===== rtl/metp_ctrl.sv =====
// Sequencer for the escape-time pixel unit: mapping, iteration loop, palette division.
module metp_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    output logic                  o_busy,
    output logic                  o_done,
    output metp_pkg::t_dp_cmd     o_cmd,
    input  metp_pkg::t_dp_status  i_status
);

    localparam logic [metp_pkg::STEP_W-1:0] LAST_STEP =
        metp_pkg::STEP_W'(metp_pkg::QUOT_W - 1);

    metp_pkg::t_state             r_state, n_state;
    logic [metp_pkg::STEP_W-1:0]  r_step, n_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= metp_pkg::S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        o_cmd   = '0;
        o_busy  = 1'b1;
        o_done  = 1'b0;
        unique case (r_state)
            metp_pkg::S_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = metp_pkg::S_MAP;
                end
            end
            metp_pkg::S_MAP: begin
                o_cmd.map_add = 1'b1;
                n_state       = metp_pkg::S_IT_MUL;
            end
            metp_pkg::S_IT_MUL: begin
                o_cmd.it_mul = 1'b1;
                n_state      = metp_pkg::S_IT_UPD;
            end
            metp_pkg::S_IT_UPD: begin
                o_cmd.it_upd = 1'b1;
                n_state      = i_status.it_finish ? metp_pkg::S_DIV_INIT : metp_pkg::S_IT_MUL;
            end
            metp_pkg::S_DIV_INIT: begin
                o_cmd.div_init = 1'b1;
                n_step         = '0;
                n_state        = metp_pkg::S_DIV_STEP;
            end
            metp_pkg::S_DIV_STEP: begin
                o_cmd.div_step = 1'b1;
                if (r_step == LAST_STEP) begin
                    n_state = metp_pkg::S_DONE;
                end else begin
                    n_step = r_step + metp_pkg::STEP_W'(1);
                end
            end
            metp_pkg::S_DONE: begin
                // result shows this cycle; a new request may enter at once
                o_busy = 1'b0;
                o_done = 1'b1;
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = metp_pkg::S_MAP;
                end else begin
                    n_state = metp_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = metp_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/metp_datapath.sv =====
// Datapath: configuration registers, coordinate mapping, z update and restoring divider.
module metp_datapath #(
    parameter int PIXEL_INDEX_BITS = 10,
    parameter int COUNT_BITS       = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [metp_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [metp_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic [PIXEL_INDEX_BITS-1:0]        i_pixel_row,
    input  logic [PIXEL_INDEX_BITS-1:0]        i_pixel_col,
    input  metp_pkg::t_dp_cmd                  i_cmd,
    output metp_pkg::t_dp_status               o_status,
    output logic [COUNT_BITS-1:0]              o_iteration_count,
    output logic [metp_pkg::PALETTE_W-1:0]     o_palette_index
);

    localparam int W      = metp_pkg::WORD_W;
    localparam int PW     = metp_pkg::PROD_W;
    localparam int MAP_W  = PIXEL_INDEX_BITS + 1 + W;
    localparam int LIM_W  = ((COUNT_BITS > metp_pkg::MAX_ITER_W) ?
                             COUNT_BITS : metp_pkg::MAX_ITER_W) + 1;
    localparam int DIV_W  = COUNT_BITS + metp_pkg::COLOR_W;
    localparam int QW     = metp_pkg::QUOT_W;

    localparam logic signed [PW-1:0] WORD_MAX = PW'((64'sd1 <<< (W - 1)) - 64'sd1);
    localparam logic signed [PW-1:0] WORD_MIN = -PW'(64'sd1 <<< (W - 1));
    localparam logic [PW-1:0]        FOUR     = PW'(4) << metp_pkg::FRAC_BITS;

    function automatic logic signed [W-1:0] sat_word(input logic signed [PW-1:0] v);
        logic signed [W-1:0] res;
        if (v > WORD_MAX) begin
            res = WORD_MAX[W-1:0];
        end else if (v < WORD_MIN) begin
            res = WORD_MIN[W-1:0];
        end else begin
            res = v[W-1:0];
        end
        return res;
    endfunction

    // configuration
    logic signed [W-1:0]                  r_x_origin, r_x_step, r_y_origin, r_y_step;
    logic [metp_pkg::MAX_ITER_W-1:0]      r_max_iter;

    // per-pixel state
    logic signed [MAP_W-1:0]  r_map_re, r_map_im;
    logic [COUNT_BITS-1:0]    r_limit;
    logic signed [W-1:0]      r_c_re, r_c_im;
    logic signed [W-1:0]      r_zr, r_zi;
    logic signed [PW-1:0]     r_p_rr, r_p_ii, r_p_ri;
    logic [COUNT_BITS-1:0]    r_count;
    logic [DIV_W-1:0]         r_rem, r_dvs;
    logic [QW-1:0]            r_quot;

    logic signed [MAP_W-1:0]  w_map_re, w_map_im;
    logic [LIM_W-1:0]         w_max_ext, w_cap, w_lim_lo, w_lim;
    logic signed [PW-1:0]     w_p_rr, w_p_ii, w_p_ri;
    logic [PW-1:0]            w_zr2, w_zi2, w_sq_sum;
    logic signed [PW-1:0]     w_new_re, w_cross, w_new_im;
    logic                     w_finish;
    logic                     w_ge;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_origin <= '0;
            r_x_step   <= '0;
            r_y_origin <= '0;
            r_y_step   <= '0;
            r_max_iter <= metp_pkg::MAX_ITER_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                metp_pkg::CFG_X_ORIGIN: r_x_origin <= i_cfg_data[W-1:0];
                metp_pkg::CFG_X_STEP:   r_x_step   <= i_cfg_data[W-1:0];
                metp_pkg::CFG_Y_ORIGIN: r_y_origin <= i_cfg_data[W-1:0];
                metp_pkg::CFG_Y_STEP:   r_y_step   <= i_cfg_data[W-1:0];
                metp_pkg::CFG_MAX_ITER: r_max_iter <= i_cfg_data[metp_pkg::MAX_ITER_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign w_map_re = $signed({1'b0, i_pixel_col}) * r_x_step;
    assign w_map_im = $signed({1'b0, i_pixel_row}) * r_y_step;

    // zero limit acts as one; cap at what the counter holds
    assign w_max_ext = LIM_W'(r_max_iter);
    assign w_cap     = (LIM_W'(1) << COUNT_BITS) - LIM_W'(1);
    assign w_lim_lo  = (r_max_iter == '0) ? LIM_W'(1) : w_max_ext;
    assign w_lim     = (w_lim_lo > w_cap) ? w_cap : w_lim_lo;

    assign w_p_rr = r_zr * r_zr;
    assign w_p_ii = r_zi * r_zi;
    assign w_p_ri = r_zr * r_zi;

    assign w_zr2    = $unsigned(r_p_rr) >> metp_pkg::FRAC_BITS;
    assign w_zi2    = $unsigned(r_p_ii) >> metp_pkg::FRAC_BITS;
    assign w_sq_sum = w_zr2 + w_zi2;
    assign w_new_re = $signed(w_zr2) - $signed(w_zi2) + PW'(r_c_re);
    // doubled cross term, floored
    assign w_cross  = r_p_ri >>> (metp_pkg::FRAC_BITS - 1);
    assign w_new_im = w_cross + PW'(r_c_im);
    assign w_finish = (w_sq_sum >= FOUR) || (r_count >= r_limit);

    assign w_ge = (r_rem >= r_dvs);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_map_re <= w_map_re;
            r_map_im <= w_map_im;
            r_limit  <= COUNT_BITS'(w_lim);
        end
        if (i_cmd.map_add) begin
            r_c_re  <= sat_word(PW'(r_x_origin) + PW'(r_map_re));
            r_c_im  <= sat_word(PW'(r_y_origin) + PW'(r_map_im));
            r_zr    <= '0;
            r_zi    <= '0;
            r_count <= '0;
        end
        if (i_cmd.it_mul) begin
            r_p_rr <= w_p_rr;
            r_p_ii <= w_p_ii;
            r_p_ri <= w_p_ri;
        end
        if (i_cmd.it_upd && !w_finish) begin
            r_zr    <= sat_word(w_new_re);
            r_zi    <= sat_word(w_new_im);
            r_count <= r_count + COUNT_BITS'(1);
        end
        if (i_cmd.div_init) begin
            r_rem  <= DIV_W'(r_count - COUNT_BITS'(1)) * DIV_W'(metp_pkg::COLOR_COUNT);
            r_dvs  <= DIV_W'(r_limit) << (QW - 1);
            r_quot <= '0;
        end
        if (i_cmd.div_step) begin
            if (w_ge) begin
                r_rem <= r_rem - r_dvs;
            end
            r_quot <= QW'({r_quot, w_ge});
            r_dvs  <= r_dvs >> 1;
        end
    end

    assign o_status.it_finish = w_finish;
    assign o_iteration_count  = r_count;
    assign o_palette_index    = metp_pkg::PALETTE_W'(r_quot);

endmodule

// ===== rtl/mandelbrot_escape_time_pixel_unit.sv =====
// Top level of the escape-time pixel unit: sequencer and datapath.
//
//  channel   | handshake                  | payload
//  ----------+----------------------------+------------------------------------------
//  request   | start in, busy out         | i_pixel_row, i_pixel_col
//  result    | o_done strobe, one cycle   | o_iteration_count, o_palette_index
//  config    | i_cfg_we, i_cfg_index      | i_cfg_data (0..3 coordinates, 4 limit)
//
// A request passes through coordinate mapping, the iteration loop (multiply,
// then update and escape test, repeated per iteration) and the palette
// division on its way to its result strobe; the reset limit is 60.
// One request is in flight at a time; a new one may be accepted in the cycle
// that shows the result. Reset is synchronous and active low and restores the
// register defaults. Results cannot be stalled: o_done is high for one cycle.
module mandelbrot_escape_time_pixel_unit #(
    parameter int PIXEL_INDEX_BITS = 10,
    parameter int COUNT_BITS       = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [PIXEL_INDEX_BITS-1:0]        i_pixel_row,
    input  logic [PIXEL_INDEX_BITS-1:0]        i_pixel_col,
    output logic                               o_done,
    output logic [COUNT_BITS-1:0]              o_iteration_count,
    output logic [metp_pkg::PALETTE_W-1:0]     o_palette_index,
    input  logic                               i_cfg_we,
    input  logic [metp_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [metp_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    metp_pkg::t_dp_cmd     w_cmd;
    metp_pkg::t_dp_status  w_status;

    metp_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .o_busy   (busy),
        .o_done   (o_done),
        .o_cmd    (w_cmd),
        .i_status (w_status)
    );

    metp_datapath #(
        .PIXEL_INDEX_BITS (PIXEL_INDEX_BITS),
        .COUNT_BITS       (COUNT_BITS)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_pixel_row       (i_pixel_row),
        .i_pixel_col       (i_pixel_col),
        .i_cmd             (w_cmd),
        .o_status          (w_status),
        .o_iteration_count (o_iteration_count),
        .o_palette_index   (o_palette_index)
    );

endmodule

// ===== rtl/metp_checker.sv =====
// Port-level checks for the escape-time pixel unit, bound to the top level.
module metp_checker #(
    parameter int PIXEL_INDEX_BITS = 10,
    parameter int COUNT_BITS       = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    input  logic                               busy,
    input  logic                               o_done,
    input  logic [COUNT_BITS-1:0]              o_iteration_count,
    input  logic [metp_pkg::PALETTE_W-1:0]     o_palette_index
);

    // a result strobe lasts one cycle
    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held for more than one cycle");

    // an accepted request keeps the unit busy in the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("unit not busy after accepting a request");

    // a result only follows work in progress
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
        else $error("result strobe without a request in flight");

    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_iteration_count != '0))
        else $error("iteration count of zero");

    a_palette_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (int'(o_palette_index) < metp_pkg::COLOR_COUNT))
        else $error("palette index beyond colour count");

endmodule

bind mandelbrot_escape_time_pixel_unit metp_checker #(
    .PIXEL_INDEX_BITS (PIXEL_INDEX_BITS),
    .COUNT_BITS       (COUNT_BITS)
) u_metp_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .start             (start),
    .busy              (busy),
    .o_done            (o_done),
    .o_iteration_count (o_iteration_count),
    .o_palette_index   (o_palette_index)
);

// ===== bench/tb_mandelbrot_escape_time_pixel_unit.sv =====
// Self-checking bench for the escape-time pixel unit: paced requests, register views, scoreboard.
`timescale 1ns / 1ps

module tb_mandelbrot_escape_time_pixel_unit;

    localparam int PIX_W     = 10;
    localparam int CNT_W     = 16;
    localparam int Q_ONE     = 1 << metp_pkg::FRAC_BITS;
    // Guard against a hang: the limit allows several times the slowest legal run.
    localparam int RUN_LIMIT = 4_000_000;

    typedef struct packed {
        logic [CNT_W-1:0]               count;
        logic [metp_pkg::PALETTE_W-1:0] palette;
    } t_pixel_result;

    class t_escape_tracker;
        int                              x_origin;
        int                              x_step;
        int                              y_origin;
        int                              y_step;
        logic [metp_pkg::MAX_ITER_W-1:0] max_iter;
        t_pixel_result                   awaited[$];
        int                              errors;

        function new();
            x_origin = 0;
            x_step   = 0;
            y_origin = 0;
            y_step   = 0;
            max_iter = metp_pkg::MAX_ITER_RESET;
            errors   = 0;
        endfunction

        function void set_register(logic [metp_pkg::CFG_IDX_W-1:0] idx,
                                   logic [metp_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                metp_pkg::CFG_X_ORIGIN: x_origin = data;
                metp_pkg::CFG_X_STEP:   x_step   = data;
                metp_pkg::CFG_Y_ORIGIN: y_origin = data;
                metp_pkg::CFG_Y_STEP:   y_step   = data;
                metp_pkg::CFG_MAX_ITER: max_iter = data[metp_pkg::MAX_ITER_W-1:0];
                default: ;
            endcase
        endfunction

        function longint clamp_word(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        function longint unsigned square_q(longint v);
            longint unsigned m;
            m = (v < 0) ? -v : v;
            return (m * m) >> metp_pkg::FRAC_BITS;
        endfunction

        function t_pixel_result escape_time(logic [PIX_W-1:0] row, logic [PIX_W-1:0] col);
            longint          c_re, c_im, zr, zi, cross_term, nr;
            longint unsigned zr2, zi2, limit, count, four;
            t_pixel_result   res;
            c_re  = clamp_word(longint'(x_origin) + longint'(col) * longint'(x_step));
            c_im  = clamp_word(longint'(y_origin) + longint'(row) * longint'(y_step));
            limit = max_iter;
            if (limit == 0) limit = 1;
            if (limit > (64'd1 << CNT_W) - 1) limit = (64'd1 << CNT_W) - 1;
            four  = 64'd4 << metp_pkg::FRAC_BITS;
            zr    = 0;
            zi    = 0;
            zr2   = 0;
            zi2   = 0;
            count = 0;
            while (zr2 + zi2 < four && count < limit) begin
                // 2*zr*zi in Q.FRAC_BITS, floored
                cross_term = (zr * zi) >>> (metp_pkg::FRAC_BITS - 1);
                nr         = longint'(zr2) - longint'(zi2) + c_re;
                zi         = clamp_word(cross_term + c_im);
                zr         = clamp_word(nr);
                zr2        = square_q(zr);
                zi2        = square_q(zi);
                count++;
            end
            res.count   = CNT_W'(count);
            res.palette = metp_pkg::PALETTE_W'(((count - 1) * metp_pkg::COLOR_COUNT) / limit);
            return res;
        endfunction

        function void note_pixel(logic [PIX_W-1:0] row, logic [PIX_W-1:0] col);
            awaited.push_back(escape_time(row, col));
        endfunction

        function void check_result(logic [CNT_W-1:0] count,
                                   logic [metp_pkg::PALETTE_W-1:0] palette);
            t_pixel_result want;
            if (awaited.size() == 0) begin
                $error("result with no request outstanding: iteration_count %0d palette_index %0d",
                       count, palette);
                errors++;
                return;
            end
            want = awaited.pop_front();
            if (count !== want.count) begin
                $error("iteration_count expected %0d actual %0d", want.count, count);
                errors++;
            end
            if (palette !== want.palette) begin
                $error("palette_index expected %0d actual %0d", want.palette, palette);
                errors++;
            end
        endfunction

        function int pending();
            return awaited.size();
        endfunction
    endclass

    logic                            i_clk;
    logic                            i_rst_n     = 1'b0;
    logic                            start       = 1'b0;
    logic                            busy;
    logic [PIX_W-1:0]                i_pixel_row = '0;
    logic [PIX_W-1:0]                i_pixel_col = '0;
    logic                            o_done;
    logic [CNT_W-1:0]                o_iteration_count;
    logic [metp_pkg::PALETTE_W-1:0]  o_palette_index;
    logic                            i_cfg_we    = 1'b0;
    logic [metp_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [metp_pkg::CFG_DATA_W-1:0] i_cfg_data  = '0;

    t_escape_tracker board;
    int              burst_left  = 0;
    int unsigned     cycle_count = 0;

    mandelbrot_escape_time_pixel_unit #(
        .PIXEL_INDEX_BITS(PIX_W),
        .COUNT_BITS      (CNT_W)
    ) DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_pixel_row      (i_pixel_row),
        .i_pixel_col      (i_pixel_col),
        .o_done           (o_done),
        .o_iteration_count(o_iteration_count),
        .o_palette_index  (o_palette_index),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) board.check_result(o_iteration_count, o_palette_index);
    end

    task automatic write_reg(logic [metp_pkg::CFG_IDX_W-1:0] idx,
                             logic [metp_pkg::CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        board.set_register(idx, data);
    endtask

    task automatic program_view(int xo, int xs, int yo, int ys, logic [31:0] lim_word,
                                bit poke_unknown);
        write_reg(metp_pkg::CFG_X_ORIGIN, xo);
        write_reg(metp_pkg::CFG_X_STEP, xs);
        write_reg(metp_pkg::CFG_Y_ORIGIN, yo);
        write_reg(metp_pkg::CFG_Y_STEP, ys);
        write_reg(metp_pkg::CFG_MAX_ITER, lim_word);
        // an unmapped index must leave every register untouched
        if (poke_unknown)
            write_reg(metp_pkg::CFG_IDX_W'(int'(metp_pkg::CFG_MAX_ITER) + 1
                                           + $urandom_range(0, 2)), $urandom);
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_pixel(logic [PIX_W-1:0] row, logic [PIX_W-1:0] col);
        start       <= 1'b1;
        i_pixel_row <= row;
        i_pixel_col <= col;
        do @(posedge i_clk); while (busy);
        board.note_pixel(row, col);
    endtask

    // Hold start high through a burst; drop it for a random gap between bursts.
    task automatic pace_requests();
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            start <= 1'b0;
            repeat (($urandom_range(0, 3) == 0) ? $urandom_range(9, 300) : $urandom_range(1, 8))
                @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 6);
        end
    endtask

    task automatic run_pixel(logic [PIX_W-1:0] row, logic [PIX_W-1:0] col);
        send_pixel(row, col);
        pace_requests();
    endtask

    task automatic settle();
        start <= 1'b0;
        while (board.pending() > 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic int pick_extreme();
        case ($urandom_range(0, 4))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 0;
            3:       return -1;
            default: return $urandom;
        endcase
    endfunction

    initial begin
        int          mode, xo, xs, yo, ys;
        logic [31:0] lim_word;
        board = new();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset view: c is zero everywhere, so every pixel runs to the reset limit
        run_pixel(0, 0);
        run_pixel(10'd1023, 10'd1023);
        settle();

        // classic view with junk in the upper limit bits
        program_view(-2 * Q_ONE, 3 * Q_ONE / 1024, -(Q_ONE / 5 * 6), Q_ONE / 5 * 12 / 1024,
                     {16'hA5C3, 16'd60}, 1'b1);
        run_pixel(0, 0);
        run_pixel(0, 10'd1023);
        run_pixel(10'd1023, 0);
        run_pixel(10'd1023, 10'd1023);
        run_pixel(512, 683);
        run_pixel(512, 341);
        run_pixel(512, 900);
        run_pixel(300, 500);
        settle();

        // limit of one, then a zero limit that behaves as one
        program_view(-2 * Q_ONE, 3 * Q_ONE / 1024, -(Q_ONE / 5 * 6), Q_ONE / 5 * 12 / 1024,
                     32'd1, 1'b0);
        run_pixel(512, 683);
        run_pixel(0, 0);
        run_pixel(10'd1023, 10'd341);
        settle();
        program_view(-2 * Q_ONE, 3 * Q_ONE / 1024, -(Q_ONE / 5 * 6), Q_ONE / 5 * 12 / 1024,
                     32'hFFFF_0000, 1'b0);
        run_pixel(512, 683);
        run_pixel(10'd1023, 10'd1023);
        run_pixel(0, 10'd682);
        settle();

        // saturating coordinates at the widest limit
        program_view(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                     32'h0000_FFFF, 1'b1);
        run_pixel(10'd1023, 10'd1023);
        run_pixel(0, 0);
        run_pixel(10'd1023, 0);
        settle();

        // single long request that runs the full widest limit
        program_view(0, 0, 0, 0, 32'h0000_FFFF, 1'b0);
        run_pixel(10'd1023, 0);
        settle();

        for (int phase = 0; phase < 10; phase++) begin
            mode = $urandom_range(0, 9);
            if (mode < 8) begin
                xo = -int'($urandom_range(Q_ONE / 2, Q_ONE / 2 * 5));
                xs = $urandom_range(Q_ONE / 5120, Q_ONE / 256);
                yo = -int'($urandom_range(Q_ONE / 10 * 3, Q_ONE / 5 * 8));
                ys = xs * 3 / 5 + $urandom_range(0, 255);
                // mirror the same window by counting from the far edge
                if ($urandom_range(0, 3) == 0) begin
                    xo = xo + 1023 * xs;
                    xs = -xs;
                end
                if ($urandom_range(0, 3) == 0) begin
                    yo = yo + 1023 * ys;
                    ys = -ys;
                end
            end else if (mode == 8) begin
                xo = $urandom;
                xs = $urandom;
                yo = $urandom;
                ys = $urandom;
            end else begin
                xo = pick_extreme();
                xs = pick_extreme();
                yo = pick_extreme();
                ys = pick_extreme();
            end
            lim_word = {16'($urandom),
                        16'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 3)
                                                        : $urandom_range(4, 255))};
            program_view(xo, xs, yo, ys, lim_word, $urandom_range(0, 1));
            repeat (90) run_pixel(PIX_W'($urandom), PIX_W'($urandom));
            settle();
        end

        repeat (600) @(posedge i_clk);
        if (board.errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
